>>> rtl/sbds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbds_pkg
// Shared constants, types and helpers for the serial baud divisor search.
// ----------------------------------------------------------------------------
package sbds_pkg;

   localparam int unsigned PRESCALER_COUNT = 4;
   localparam int unsigned SCALER_COUNT    = 16;
   localparam int unsigned CAND_COUNT      = PRESCALER_COUNT * SCALER_COUNT;
   localparam int unsigned CAND_BITS       = $clog2(CAND_COUNT);
   localparam int unsigned SCALER_BITS     = $clog2(SCALER_COUNT);
   localparam int unsigned PRESCALER_BITS  = $clog2(PRESCALER_COUNT);

   localparam logic [31:0] CLOCK_RESET = 32'd50000000;
   localparam logic [31:0] DIFF_START  = 32'hFFFF_FFFF;

   // reciprocal constants for divide by 3, 5 and 7 of a 32 bit word
   localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
   localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;
   localparam logic [31:0] RECIP7 = 32'h2492_4925;

   // quotients of the module clock by 2, 3, 5, 7 in that order
   typedef logic [PRESCALER_COUNT-1:0][31:0] quot_vec_type;

   typedef struct packed {
      logic [31:0]          diff;
      logic [CAND_BITS-1:0] index;
   } cand_type;

   // lower index wins on equal difference
   function automatic cand_type pick_better(cand_type a, cand_type b);
      pick_better = (b.diff < a.diff) ? b : a;
   endfunction

   function automatic logic [31:0] abs_diff(logic [31:0] a, logic [31:0] b);
      abs_diff = (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

>>> rtl/sbds_quot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbds_quot
// Divides the module clock by each prescaler through reciprocal multiplies.
// ----------------------------------------------------------------------------
module sbds_quot (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [31:0]           in_clock_hz,
   input  logic [31:0]           in_baud,
   output logic                  out_valid,
   output sbds_pkg::quot_vec_type out_quot,
   output logic [31:0]           out_baud
);

   logic [63:0] prod3_in;
   logic [63:0] prod5_in;
   logic [63:0] prod7_in;

   logic        valid_ff;
   logic [31:0] clock_hz_ff;
   logic [31:0] baud_ff;
   logic [30:0] q3_ff;
   logic [29:0] q5_ff;
   logic [31:0] t7_ff;

   logic [31:0] diff7;
   logic [31:0] sum7;

   assign prod3_in = {32'b0, in_clock_hz} * {32'b0, sbds_pkg::RECIP3};
   assign prod5_in = {32'b0, in_clock_hz} * {32'b0, sbds_pkg::RECIP5};
   assign prod7_in = {32'b0, in_clock_hz} * {32'b0, sbds_pkg::RECIP7};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      clock_hz_ff <= in_clock_hz;
      baud_ff     <= in_baud;
      q3_ff       <= prod3_in[63:33];
      q5_ff       <= prod5_in[63:34];
      t7_ff       <= prod7_in[63:32];
   end

   // divide by 7 fixup: ((n - t) / 2 + t) / 4
   assign diff7 = clock_hz_ff - t7_ff;
   assign sum7  = {1'b0, diff7[31:1]} + t7_ff;

   assign out_valid   = valid_ff;
   assign out_baud    = baud_ff;
   assign out_quot[0] = {1'b0, clock_hz_ff[31:1]};
   assign out_quot[1] = {1'b0, q3_ff};
   assign out_quot[2] = {2'b0, q5_ff};
   assign out_quot[3] = {2'b0, sum7[31:2]};

   a_quot3 : assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ({2'b0, out_quot[1]} * 34'd3 <= {2'b0, clock_hz_ff})
                && ({2'b0, clock_hz_ff} - {2'b0, out_quot[1]} * 34'd3 < 34'd3))
      else $error("divide by 3 out of range");

   a_quot5 : assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ({3'b0, out_quot[2]} * 35'd5 <= {3'b0, clock_hz_ff})
                && ({3'b0, clock_hz_ff} - {3'b0, out_quot[2]} * 35'd5 < 35'd5))
      else $error("divide by 5 out of range");

   a_quot7 : assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ({3'b0, out_quot[3]} * 35'd7 <= {3'b0, clock_hz_ff})
                && ({3'b0, clock_hz_ff} - {3'b0, out_quot[3]} * 35'd7 < 35'd7))
      else $error("divide by 7 out of range");

endmodule

>>> rtl/sbds_min_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbds_min_tree
// Forms all 64 scaled differences and reduces them in a registered tree.
// ----------------------------------------------------------------------------
module sbds_min_tree (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  sbds_pkg::quot_vec_type in_quot,
   input  logic [31:0]           in_baud,
   output logic                  out_valid,
   output logic [sbds_pkg::PRESCALER_BITS-1:0] out_prescaler_select,
   output logic [sbds_pkg::SCALER_BITS-1:0]    out_scaler_select
);

   localparam int unsigned GROUP_COUNT = sbds_pkg::CAND_COUNT / 4;
   localparam int unsigned QUAD_COUNT  = GROUP_COUNT / 4;

   sbds_pkg::cand_type diff_in  [sbds_pkg::CAND_COUNT];
   sbds_pkg::cand_type diff_ff  [sbds_pkg::CAND_COUNT];
   sbds_pkg::cand_type group_in [GROUP_COUNT];
   sbds_pkg::cand_type group_ff [GROUP_COUNT];
   sbds_pkg::cand_type quad_in  [QUAD_COUNT];
   sbds_pkg::cand_type quad_ff  [QUAD_COUNT];
   sbds_pkg::cand_type best_in;

   logic [3:0] valid_ff;
   logic [sbds_pkg::CAND_BITS-1:0] result_in;
   logic [sbds_pkg::CAND_BITS-1:0] result_ff;

   for (genvar p = 0; p < sbds_pkg::PRESCALER_COUNT; p++) begin : g_pre
      for (genvar s = 0; s < sbds_pkg::SCALER_COUNT; s++) begin : g_scl
         localparam int unsigned IDX = p * sbds_pkg::SCALER_COUNT + s;
         assign diff_in[IDX].diff  = sbds_pkg::abs_diff(in_quot[p] >> (s + 1), in_baud);
         assign diff_in[IDX].index = sbds_pkg::CAND_BITS'(IDX);
      end
   end

   for (genvar g = 0; g < GROUP_COUNT; g++) begin : g_group
      assign group_in[g] = sbds_pkg::pick_better(
         sbds_pkg::pick_better(diff_ff[4*g],   diff_ff[4*g+1]),
         sbds_pkg::pick_better(diff_ff[4*g+2], diff_ff[4*g+3]));
   end

   for (genvar q = 0; q < QUAD_COUNT; q++) begin : g_quad
      assign quad_in[q] = sbds_pkg::pick_better(
         sbds_pkg::pick_better(group_ff[4*q],   group_ff[4*q+1]),
         sbds_pkg::pick_better(group_ff[4*q+2], group_ff[4*q+3]));
   end

   assign best_in = sbds_pkg::pick_better(
      sbds_pkg::pick_better(quad_ff[0], quad_ff[1]),
      sbds_pkg::pick_better(quad_ff[2], quad_ff[3]));

   // nothing beats the start value: answer the first pair
   assign result_in = (best_in.diff < sbds_pkg::DIFF_START) ? best_in.index : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      diff_ff   <= diff_in;
      group_ff  <= group_in;
      quad_ff   <= quad_in;
      result_ff <= result_in;
   end

   assign out_valid            = valid_ff[3];
   assign out_prescaler_select = result_ff[sbds_pkg::CAND_BITS-1:sbds_pkg::SCALER_BITS];
   assign out_scaler_select    = result_ff[sbds_pkg::SCALER_BITS-1:0];

   a_group_min : assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> (group_in[0].diff <= diff_ff[0].diff)
                   && (group_in[0].diff <= diff_ff[3].diff))
      else $error("group stage lost a smaller difference");

   a_quad_min : assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] |-> (quad_in[0].diff <= group_ff[0].diff)
                   && (quad_in[0].diff <= group_ff[3].diff))
      else $error("tree stage lost a smaller difference");

endmodule

>>> rtl/spi_baud_divisor_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_baud_divisor_search
// Finds the prescaler and power-of-two scaler whose divided module clock
// lands closest to a requested serial clock rate.
// ----------------------------------------------------------------------------
//  channel   ports                                        direction
//  request   start, busy, req_baud_rate                   in (busy out)
//  response  rsp_strobe, rsp_prescaler_select,            out
//            rsp_scaler_select
//  csr       csr_write_enable, csr_write_data             in
//
//  a word is taken on any edge with start high; busy is always low
//  one word per cycle, the result strobed after these registered stages:
//  input register, reciprocal multiply, difference bank, three tree levels
//  synchronous reset clears the pipeline valid bits and loads the module clock default
//  the response has no back pressure; each strobe is a one cycle pulse
// ----------------------------------------------------------------------------
module spi_baud_divisor_search (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_baud_rate,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_prescaler_select,
   output logic [3:0]  rsp_scaler_select,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   logic        accept;
   logic [31:0] module_clock_ff;
   logic [31:0] module_clock_in;
   logic        req_valid_ff;
   logic [31:0] req_baud_ff;
   logic [31:0] req_clock_ff;

   logic                   quot_valid;
   sbds_pkg::quot_vec_type quot;
   logic [31:0]            quot_baud;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign module_clock_in = csr_write_enable ? csr_write_data : module_clock_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         module_clock_ff <= sbds_pkg::CLOCK_RESET;
         req_valid_ff    <= 1'b0;
      end else begin
         module_clock_ff <= module_clock_in;
         req_valid_ff    <= accept;
      end
   end

   always_ff @(posedge clock) begin
      req_baud_ff  <= req_baud_rate;
      req_clock_ff <= module_clock_ff;
   end

   sbds_quot u_quot (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid_ff),
      .in_clock_hz (req_clock_ff),
      .in_baud     (req_baud_ff),
      .out_valid   (quot_valid),
      .out_quot    (quot),
      .out_baud    (quot_baud)
   );

   sbds_min_tree u_min_tree (
      .clock                (clock),
      .reset                (reset),
      .in_valid             (quot_valid),
      .in_quot              (quot),
      .in_baud              (quot_baud),
      .out_valid            (rsp_strobe),
      .out_prescaler_select (rsp_prescaler_select),
      .out_scaler_select    (rsp_scaler_select)
   );

   a_word_out : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##6 rsp_strobe)
      else $error("accepted word produced no response");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 6))
      else $error("response without a request");

endmodule

>>> bench/spi_baud_divisor_search_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_baud_divisor_search_test
// Drives requested baud rates into the divisor search under several module
// clock settings. Each word's closest prescaler and scaler pair is worked out
// here and compared field by field with the strobed result, in order.
// ----------------------------------------------------------------------------
module spi_baud_divisor_search_test;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned PHASE_COUNT   = 8;
   localparam int unsigned RANDOM_WORDS  = 175;
   localparam int unsigned SETTLE_CYCLES = 10;

   class divisor_pair_scoreboard;
      typedef struct packed {
         logic [1:0] prescaler;
         logic [3:0] scaler;
      } pair_type;

      logic [31:0] module_clock;
      pair_type    closest_pairs[$];
      int unsigned failures;

      function new();
         module_clock = sbds_pkg::CLOCK_RESET;
         failures     = 0;
      endfunction

      // module clock after the prescaler and the 2^(s+1) scaler, truncated
      function logic [31:0] divided_rate(int unsigned p, int unsigned s);
         logic [31:0] factor;
         case (p)
            0: factor = 32'd2;
            1: factor = 32'd3;
            2: factor = 32'd5;
            default: factor = 32'd7;
         endcase
         return module_clock / (factor << (s + 1));
      endfunction

      function void note_rate_request(logic [31:0] baud);
         logic [31:0] best;
         logic [31:0] rate;
         logic [31:0] gap;
         pair_type    pick;
         best = sbds_pkg::DIFF_START;
         pick = '0;
         for (int p = 0; p < sbds_pkg::PRESCALER_COUNT; p++) begin
            for (int s = 0; s < sbds_pkg::SCALER_COUNT; s++) begin
               rate = divided_rate(p, s);
               gap  = (rate >= baud) ? rate - baud : baud - rate;
               // strict compare: the first pair found keeps a tie
               if (gap < best) begin
                  best           = gap;
                  pick.prescaler = p[1:0];
                  pick.scaler    = s[3:0];
               end
            end
         end
         closest_pairs.push_back(pick);
      endfunction

      function void check_pair(logic [1:0] prescaler, logic [3:0] scaler);
         pair_type want;
         if (closest_pairs.size() == 0) begin
            $display("%0t: result with no word waiting, prescaler %0d scaler %0d",
                     $realtime, prescaler, scaler);
            failures++;
            return;
         end
         want = closest_pairs.pop_front();
         if (prescaler !== want.prescaler) begin
            $display("%0t: prescaler_select expected %0d, actual %0d",
                     $realtime, want.prescaler, prescaler);
            failures++;
         end
         if (scaler !== want.scaler) begin
            $display("%0t: scaler_select expected %0d, actual %0d",
                     $realtime, want.scaler, scaler);
            failures++;
         end
      endfunction

      function int unsigned pending();
         return closest_pairs.size();
      endfunction
   endclass

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        start            = 1'b0;
   logic [31:0] req_baud_rate    = '0;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data   = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [1:0]  rsp_prescaler_select;
   logic [3:0]  rsp_scaler_select;

   divisor_pair_scoreboard divider_check;
   int unsigned cycle_count = 0;
   int unsigned burst_left  = 0;

   spi_baud_divisor_search u_top (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_baud_rate        (req_baud_rate),
      .rsp_strobe           (rsp_strobe),
      .rsp_prescaler_select (rsp_prescaler_select),
      .rsp_scaler_select    (rsp_scaler_select),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // values read here are the ones present just before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) divider_check.note_rate_request(req_baud_rate);
         if (rsp_strobe) divider_check.check_pair(rsp_prescaler_select, rsp_scaler_select);
      end
   end

   function automatic int unsigned next_gap();
      int unsigned r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(99);
      if (r < 3) begin
         burst_left = $urandom_range(60, 20);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 4);
   endfunction

   // mostly rates at or near a divider output, where the choice is tight
   function automatic logic [31:0] next_rate();
      int unsigned r;
      logic [31:0] a;
      logic [31:0] b;
      logic [32:0] sum;
      r = $urandom_range(9);
      a = divider_check.divided_rate($urandom_range(3), $urandom_range(15));
      b = divider_check.divided_rate($urandom_range(3), $urandom_range(15));
      case (r)
         0, 1, 2: return a;
         3: return a + $urandom_range(3);
         4: return a - $urandom_range(3);
         5, 6: begin
            sum = {1'b0, a} + {1'b0, b};
            return sum[32:1];
         end
         7: return $urandom;
         8: return $urandom_range(1000);
         default: return $urandom >> $urandom_range(31);
      endcase
   endfunction

   task automatic send_rate(input logic [31:0] rate, input int unsigned gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_baud_rate <= rate;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (divider_check.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_module_clock(input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      divider_check.module_clock = value;
   endtask

   task automatic send_edge_rates();
      logic [32:0] sum;
      send_rate(32'h0000_0000, next_gap());
      send_rate(32'h0000_0001, next_gap());
      send_rate(32'hFFFF_FFFF, next_gap());
      send_rate(32'h8000_0000, next_gap());
      for (int p = 0; p < 4; p++) begin
         send_rate(divider_check.divided_rate(p, 0), next_gap());
         send_rate(divider_check.divided_rate(p, 15), next_gap());
      end
      // halfway between the first two scaler steps of prescaler 0, equally far from both when the sum is even
      sum = {1'b0, divider_check.divided_rate(0, 0)} + divider_check.divided_rate(0, 1);
      send_rate(sum[32:1], next_gap());
   endtask

   initial begin
      logic [31:0] clock_setting;
      divider_check = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // phase 0 runs on the reset value of the module clock
         if (phase > 0) begin
            case (phase)
               1: clock_setting = 32'h0000_0000;
               2: clock_setting = 32'h0000_0001;
               3: clock_setting = 32'hFFFF_FFFF;
               4: clock_setting = $urandom;
               5: clock_setting = 32'd100_000_000;
               6: clock_setting = $urandom_range(5000, 2);
               default: clock_setting = $urandom_range(200_000_000, 1_000_000);
            endcase
            write_module_clock(clock_setting);
         end
         send_edge_rates();
         for (int n = 0; n < RANDOM_WORDS; n++) send_rate(next_rate(), next_gap());
         drain_results();
      end

      if (divider_check.pending() != 0) begin
         $display("%0t: %0d results never arrived", $realtime, divider_check.pending());
         divider_check.failures++;
      end
      if (divider_check.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
